>>> design/ctk_pkg.sv
package ctk_pkg;

  localparam int MAX_TOKEN_LEN = 255;
  localparam int OFFSET_BITS   = 20;
  localparam int LEN_CAP       = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam int START_W       = 20;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] KIND_END      = 4'd0;
  localparam logic [3:0] KIND_STRING   = 4'd1;
  localparam logic [3:0] KIND_IDENT    = 4'd2;
  localparam logic [3:0] KIND_NUMBER   = 4'd3;
  localparam logic [3:0] KIND_INT      = 4'd4;
  localparam logic [3:0] KIND_VAR      = 4'd5;
  localparam logic [3:0] KIND_ASM      = 4'd6;
  localparam logic [3:0] KIND_IF       = 4'd7;
  localparam logic [3:0] KIND_FUNCTION = 4'd8;
  localparam logic [3:0] KIND_INCR     = 4'd9;
  localparam logic [3:0] KIND_ADDEQ    = 4'd10;
  localparam logic [3:0] KIND_DECR     = 4'd11;
  localparam logic [3:0] KIND_CHAR     = 4'd12;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_OPEN_STR   = 2'd1;
  localparam logic [1:0] ERR_OPEN_BLOCK = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         char_code;
    logic [START_W-1:0] start_offset;
    logic [7:0]         text_length;
    logic [15:0]        line_number;
    logic [1:0]         error_code;
  } tok_t;

  // one input byte yields zero, one or two tokens
  typedef struct packed {
    tok_t first;
    tok_t second;
    logic two;
  } pair_t;

endpackage

>>> design/ctk_scan.sv
module ctk_scan (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          q_wr,
  output ctk_pkg::pair_t q_data
);
  import ctk_pkg::*;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_STRING     = 4'd1;
  localparam logic [3:0] PH_IDENT      = 4'd2;
  localparam logic [3:0] PH_NUMBER     = 4'd3;
  localparam logic [3:0] PH_SLASH      = 4'd4;
  localparam logic [3:0] PH_BLOCK      = 4'd5;
  localparam logic [3:0] PH_BLOCK_STAR = 4'd6;
  localparam logic [3:0] PH_LINE       = 4'd7;
  localparam logic [3:0] PH_PLUS       = 4'd8;
  localparam logic [3:0] PH_MINUS      = 4'd9;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] LEN_MAX  = 8'(LEN_CAP);

  logic [3:0]             phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] ofs_r, ofs_nxt;
  logic [15:0]            line_r, line_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [7:0]             tlen_r, tlen_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [7:0]             kw_r [8];

  logic       fire;
  logic [7:0] b;
  logic       b_alpha, b_digit;
  logic [7:0] grown;
  logic       e0_v, d_v, disp, line_inc, text_end, kw_we;
  logic [2:0] kw_idx;
  tok_t       e0, d;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [3:0] ident_kind(input logic [7:0] len,
                                             input logic [63:0] w);
    logic [3:0] k;
    k = KIND_IDENT;
    if (len == 8'd3 && w[63:40] == "int") k = KIND_INT;
    else if (len == 8'd3 && w[63:40] == "var") k = KIND_VAR;
    else if (len == 8'd3 && w[63:40] == "asm") k = KIND_ASM;
    else if (len == 8'd2 && w[63:48] == "if") k = KIND_IF;
    else if (len == 8'd8 && w == "function") k = KIND_FUNCTION;
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [7:0] ch,
                                  input logic [OFFSET_BITS-1:0] st,
                                  input logic [7:0] len, input logic [15:0] line,
                                  input logic [1:0] err);
    tok_t t;
    t.kind         = kind;
    t.char_code    = ch;
    t.start_offset = START_W'(st);
    t.text_length  = len;
    t.line_number  = line;
    t.error_code   = err;
    return t;
  endfunction

  assign fire     = in_valid && in_ready;
  assign in_ready = !q_full;
  assign b        = in_byte;
  assign b_alpha  = is_alpha(b);
  assign b_digit  = (b >= "0" && b <= "9");
  assign grown    = (tlen_r < LEN_MAX) ? tlen_r + 8'd1 : tlen_r;

  always_comb begin
    phase_nxt  = phase_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    pend_nxt   = pend_r;
    e0_v       = 1'b0;
    e0         = '0;
    d_v        = 1'b0;
    d          = '0;
    disp       = 1'b0;
    line_inc   = 1'b0;
    text_end   = 1'b0;
    kw_we      = 1'b0;
    kw_idx     = tlen_r[2:0];
    unique case (phase_r)
      PH_STRING: begin
        if (b == CH_QUOTE) begin
          e0_v = 1'b1;
          e0 = mk_tok(KIND_STRING, 8'd0, tstart_r, tlen_r, line_r, ERR_NONE);
          phase_nxt = PH_IDLE;
        end else if (b == 8'd0 || b == CH_CR || b == CH_LF) begin
          e0_v = 1'b1;
          e0 = mk_tok(KIND_STRING, 8'd0, tstart_r, tlen_r, line_r, ERR_OPEN_STR);
          disp = 1'b1;
        end else begin
          tlen_nxt = grown;
        end
      end
      PH_IDENT: begin
        if (b_alpha || b_digit) begin
          kw_we    = (tlen_r < 8'd8);
          tlen_nxt = grown;
        end else begin
          e0_v = 1'b1;
          e0 = mk_tok(ident_kind(tlen_r, {kw_r[0], kw_r[1], kw_r[2], kw_r[3],
                                          kw_r[4], kw_r[5], kw_r[6], kw_r[7]}),
                      8'd0, tstart_r, tlen_r, line_r, ERR_NONE);
          disp = 1'b1;
        end
      end
      PH_NUMBER: begin
        if (b_digit || b == ".") begin
          tlen_nxt = grown;
        end else begin
          e0_v = 1'b1;
          e0 = mk_tok(KIND_NUMBER, 8'd0, tstart_r, tlen_r, line_r, ERR_NONE);
          disp = 1'b1;
        end
      end
      PH_SLASH: begin
        if (b == "*") phase_nxt = PH_BLOCK;
        else if (b == "/") phase_nxt = PH_LINE;
        else begin
          e0_v = 1'b1;
          e0 = mk_tok(KIND_CHAR, pend_r, tstart_r, 8'd1, line_r, ERR_NONE);
          disp = 1'b1;
        end
      end
      PH_BLOCK, PH_BLOCK_STAR: begin
        if (b == 8'd0) begin
          e0_v = 1'b1;
          e0 = mk_tok(KIND_END, 8'd0, ofs_r, 8'd0, line_r, ERR_OPEN_BLOCK);
          text_end = 1'b1;
        end else if (b == "*") begin
          phase_nxt = PH_BLOCK_STAR;
        end else if (b == "/" && phase_r == PH_BLOCK_STAR) begin
          phase_nxt = PH_IDLE;
        end else begin
          line_inc  = (b == CH_LF);
          phase_nxt = PH_BLOCK;
        end
      end
      PH_LINE: begin
        disp = (b == 8'd0 || b == CH_LF || b == CH_CR);
      end
      PH_PLUS: begin
        if (b == "+" || b == "=") begin
          e0_v = 1'b1;
          e0 = mk_tok((b == "+") ? KIND_INCR : KIND_ADDEQ, 8'd0, tstart_r, 8'd2,
                      line_r, ERR_NONE);
          phase_nxt = PH_IDLE;
        end else begin
          e0_v = 1'b1;
          e0 = mk_tok(KIND_CHAR, pend_r, tstart_r, 8'd1, line_r, ERR_NONE);
          disp = 1'b1;
        end
      end
      PH_MINUS: begin
        if (b == "-") begin
          e0_v = 1'b1;
          e0 = mk_tok(KIND_DECR, 8'd0, tstart_r, 8'd2, line_r, ERR_NONE);
          phase_nxt = PH_IDLE;
        end else if (b_digit) begin
          phase_nxt = PH_NUMBER;
          tlen_nxt  = 8'd2;
        end else begin
          e0_v = 1'b1;
          e0 = mk_tok(KIND_CHAR, pend_r, tstart_r, 8'd1, line_r, ERR_NONE);
          disp = 1'b1;
        end
      end
      default: disp = 1'b1;
    endcase

    // dispatch of the current byte: end of text, white space, or start of a fresh token
    if (disp) begin
      phase_nxt = PH_IDLE;
      priority if (b == 8'd0) begin
        d_v = 1'b1;
        d = mk_tok(KIND_END, 8'd0, ofs_r, 8'd0, line_r, ERR_NONE);
        text_end = 1'b1;
      end else if (b <= CH_SPACE || b[7]) begin
        line_inc = (b == CH_LF);
      end else if (b == CH_QUOTE) begin
        phase_nxt  = PH_STRING;
        tstart_nxt = ofs_r + 1'b1;
        tlen_nxt   = 8'd0;
      end else if (b_alpha) begin
        phase_nxt  = PH_IDENT;
        tstart_nxt = ofs_r;
        tlen_nxt   = 8'd1;
        kw_we      = 1'b1;
        kw_idx     = 3'd0;
      end else if (b_digit) begin
        phase_nxt  = PH_NUMBER;
        tstart_nxt = ofs_r;
        tlen_nxt   = 8'd1;
      end else if (b == "/" || b == "+" || b == "-") begin
        phase_nxt  = (b == "/") ? PH_SLASH : ((b == "+") ? PH_PLUS : PH_MINUS);
        tstart_nxt = ofs_r;
        tlen_nxt   = 8'd1;
        pend_nxt   = b;
      end else begin
        d_v = 1'b1;
        d = mk_tok(KIND_CHAR, b, ofs_r, 8'd1, line_r, ERR_NONE);
      end
    end

    if (text_end) begin
      phase_nxt = PH_IDLE;
      ofs_nxt   = '0;
      line_nxt  = 16'd1;
    end else begin
      ofs_nxt  = ofs_r + 1'b1;
      line_nxt = (line_inc && line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;
    end
  end

  assign q_wr          = fire && (e0_v || d_v);
  assign q_data.first  = e0_v ? e0 : d;
  assign q_data.second = d;
  assign q_data.two    = e0_v && d_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      ofs_r    <= '0;
      line_r   <= 16'd1;
      tstart_r <= '0;
      tlen_r   <= '0;
      pend_r   <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      ofs_r    <= ofs_nxt;
      line_r   <= line_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && kw_we) begin
      kw_r[kw_idx] <= b;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0) else $error("line count reached zero");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && b == 8'd0) |=> (ofs_r == '0 && line_r == 16'd1 && phase_r == PH_IDLE))
    else $error("end of text did not restart position");

endmodule

>>> design/ctk_fifo.sv
module ctk_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  ctk_pkg::pair_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output ctk_pkg::pair_t rd_data,
  output logic           empty
);
  import ctk_pkg::*;

  pair_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   count_r;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + 1'b1;
      if (rd_en) rptr_r <= rptr_r + 1'b1;
      if (wr_en && !rd_en) count_r <= count_r + 1'b1;
      else if (rd_en && !wr_en) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wptr_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full)) else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty)) else $error("queue read while empty");

endmodule

>>> design/ctk_emit.sv
module ctk_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ctk_pkg::pair_t q_data,
  output logic           q_rd,
  output logic           out_valid,
  input  logic           out_ready,
  output ctk_pkg::tok_t  out_tok
);
  import ctk_pkg::*;

  tok_t out_r;
  logic out_v_r;
  tok_t spare_r;
  logic spare_v_r;
  logic slot_free;

  assign slot_free = !out_v_r || out_ready;
  assign q_rd      = slot_free && !spare_v_r && !q_empty;
  assign out_valid = out_v_r;
  assign out_tok   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (slot_free) begin
      if (spare_v_r) begin
        out_v_r   <= 1'b1;
        spare_v_r <= 1'b0;
      end else begin
        out_v_r   <= !q_empty;
        spare_v_r <= !q_empty && q_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (spare_v_r) begin
        out_r <= spare_r;
      end else if (!q_empty) begin
        out_r   <= q_data.first;
        spare_r <= q_data.second;
      end
    end
  end

  a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> out_v_r) else $error("second token held without a first");

endmodule

>>> design/c_like_source_tokenizer.sv
// channel  dir  tuser  tdata  content
// in_      in   -      8      tdata: text_byte[7:0]
// out_     out  4      56     tuser: kind; tdata: char_code, start_offset, text_length,
//                             line_number, error_code, zero pad
//
// one byte accepted per cycle while the queue is not full; the scanner updates its state in that cycle
// each result leaves through one output register, one per cycle unless out_tready
// holds it back; a byte that ends one token and forms another yields two results
// a four-entry queue of token pairs sits between scanner and output stage
// in_tready drops only while that queue is full; output stalls back up into it
// rst_n is synchronous; the keyword buffer is not cleared
module c_like_source_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [3:0]  out_tuser,  // kind[3:0]
  output logic [55:0] out_tdata   // char_code[7:0], start_offset[27:8],
                                  // text_length[35:28], line_number[51:36],
                                  // error_code[53:52]
);
  import ctk_pkg::*;

  logic  q_wr, q_full, q_rd, q_empty;
  pair_t q_wdata, q_rdata;
  tok_t  tok;

  ctk_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_data   (q_wdata)
  );

  ctk_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  ctk_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (tok)
  );

  assign out_tuser = tok.kind;
  assign out_tdata = {2'd0, tok.error_code, tok.line_number, tok.text_length,
                      tok.start_offset, tok.char_code};

endmodule
